FILE: hdl/dleq_pkg.sv
// ----------------------------------------------------------------------------
// dleq_pkg
// Shared types and constants for the delta list event queue.
// ----------------------------------------------------------------------------
package dleq_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int TIME_BITS   = 48;
  localparam int IDX_W       = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

  typedef logic [IDX_W-1:0]     idx_t;
  typedef logic [CNT_W-1:0]     cnt_t;
  typedef logic [CNT_W:0]       cnt_ext_t;
  typedef logic [TIME_BITS-1:0] time_t;

  // One slot of the data memory; the link lives in its own memory
  typedef struct packed {
    logic [7:0] task_id;
    time_t      delay;
    logic       virt;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef enum logic [1:0] {
    CMD_SCHEDULE = 2'd0,
    CMD_REACH    = 2'd1,
    CMD_RETIRE   = 2'd2,
    CMD_STATUS   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ERR_NONE  = 2'd0,
    ERR_EMPTY = 2'd1,
    ERR_FULL  = 2'd2
  } err_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_POP,
    S_REACH,
    S_SCHED,
    S_WALK,
    S_TIE,
    S_INS_A,
    S_INS_B,
    S_HEAD_RD,
    S_RESULT
  } state_t;

endpackage

FILE: hdl/delta_list_event_queue.sv
// ----------------------------------------------------------------------------
// delta_list_event_queue
// Time-ordered task event queue kept as a linked delta list in RAM.
// ----------------------------------------------------------------------------
// One request at a time. Status query and error cases go straight to the
// head read, reach clears the head delay and a drop-retire frees the head.
// Schedule into an empty list writes the single entry; otherwise schedule
// walks the linked list in the slot RAMs, one entry per cycle and at most
// QUEUE_DEPTH entries, plus any tied zero-delay entries skipped; retire with
// reschedule pops the head, then schedules it. The result sits in an
// output register, and the next request is taken while it waits.
module delta_list_event_queue
  import dleq_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  command,
  input  logic [7:0]  task_id,
  input  time_t       delay,
  input  logic        after_ties,
  input  logic        background,
  input  logic        drop_task,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  head_task,
  output time_t       head_delay,
  output logic        queue_empty,
  output logic        timestep_done,
  output logic        real_events_left,
  output logic [7:0]  popped_task,
  output time_t       elapsed,
  output logic [1:0]  error_code
);

  state_t state, state_next;

  idx_t                   head, slot, cur, prev, free_slot;
  cnt_t                   count, real_count, pos;
  logic [QUEUE_DEPTH-1:0] occupied;
  time_t                  d;
  logic [7:0]             tid;
  logic                   virt, pl, drop, lt;
  logic [7:0]             cur_task;
  time_t                  cur_delay;
  logic                   cur_virt;
  idx_t                   cur_link;
  err_t                   err;
  logic [7:0]             popped;
  time_t                  elapsed_r;

  // RAM ports
  idx_t   rd_addr;
  entry_t rd;
  idx_t   lnk_rd;
  logic   dwe, lwe;
  idx_t   dwaddr, lwaddr;
  entry_t dwdata;
  idx_t   lwdata;

  logic more1, more2, go_out;

  dleq_ram #(.WIDTH(ENTRY_W), .DEPTH(QUEUE_DEPTH)) u_data (
    .clk(clk), .we(dwe), .waddr(dwaddr), .wdata(dwdata),
    .raddr(rd_addr), .rdata(rd)
  );

  dleq_ram #(.WIDTH(IDX_W), .DEPTH(QUEUE_DEPTH)) u_link (
    .clk(clk), .we(lwe), .waddr(lwaddr), .wdata(lwdata),
    .raddr(rd_addr), .rdata(lnk_rd)
  );

  // Lowest free slot
  always_comb begin
    free_slot = '0;
    for (int i = QUEUE_DEPTH - 1; i >= 0; i--) begin
      if (!occupied[i]) begin
        free_slot = idx_t'(i);
      end
    end
  end

  assign more1  = (cnt_ext_t'(pos) + cnt_ext_t'(1)) < cnt_ext_t'(count);
  assign more2  = (cnt_ext_t'(pos) + cnt_ext_t'(2)) < cnt_ext_t'(count);
  assign go_out = !out_valid || !out_stall;
  assign in_stall = (state != S_IDLE);

  // Next state and RAM control
  always_comb begin
    state_next = state;
    rd_addr    = head;
    dwe        = 1'b0;
    dwaddr     = slot;
    dwdata     = '0;
    lwe        = 1'b0;
    lwaddr     = slot;
    lwdata     = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          unique case (cmd_t'(command))
            CMD_SCHEDULE: state_next = (count == cnt_t'(QUEUE_DEPTH)) ? S_HEAD_RD : S_SCHED;
            CMD_REACH:    state_next = (count == '0) ? S_HEAD_RD : S_REACH;
            CMD_RETIRE:   state_next = (count == '0) ? S_HEAD_RD : S_POP;
            CMD_STATUS:   state_next = S_HEAD_RD;
            default:      state_next = S_HEAD_RD;
          endcase
        end
      end
      S_POP: begin
        state_next = drop ? S_HEAD_RD : S_SCHED;
      end
      S_REACH: begin
        dwe        = 1'b1;
        dwaddr     = head;
        dwdata     = '{task_id: rd.task_id, delay: '0, virt: rd.virt};
        state_next = S_HEAD_RD;
      end
      S_SCHED: begin
        if (count == '0) begin
          dwe        = 1'b1;
          dwdata     = '{task_id: tid, delay: d, virt: virt};
          lwe        = 1'b1;
          lwdata     = '0;
          state_next = S_HEAD_RD;
        end else begin
          state_next = S_WALK;
        end
      end
      S_WALK: begin
        if (d > rd.delay && more1) begin
          rd_addr = lnk_rd;
        end else if (pl && d == rd.delay && more1) begin
          rd_addr    = lnk_rd;
          state_next = S_TIE;
        end else begin
          state_next = S_INS_A;
        end
      end
      S_TIE: begin
        if (rd.delay == '0 && more2) begin
          rd_addr = lnk_rd;
        end else begin
          state_next = S_INS_A;
        end
      end
      S_INS_A: begin
        dwe = 1'b1;
        lwe = 1'b1;
        if (d < cur_delay) begin
          dwdata = '{task_id: tid, delay: d, virt: virt};
          lwdata = cur;
        end else begin
          dwdata  = '{task_id: tid, delay: d - cur_delay, virt: virt};
          lwdata  = more1 ? cur_link : '0;
          rd_addr = cur_link;
        end
        state_next = S_INS_B;
      end
      S_INS_B: begin
        if (lt) begin
          dwe    = 1'b1;
          dwaddr = cur;
          dwdata = '{task_id: cur_task, delay: cur_delay - d, virt: cur_virt};
          lwe    = (pos != '0);
          lwaddr = prev;
          lwdata = slot;
        end else begin
          lwe    = 1'b1;
          lwaddr = cur;
          lwdata = slot;
          dwe    = more1;
          dwaddr = cur_link;
          dwdata = '{task_id: rd.task_id, delay: rd.delay - d, virt: rd.virt};
        end
        state_next = S_HEAD_RD;
      end
      S_HEAD_RD: begin
        state_next = S_RESULT;
      end
      S_RESULT: begin
        if (go_out) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Control state and list bookkeeping
  always_ff @(posedge clk) begin
    if (rst) begin
      head       <= '0;
      count      <= '0;
      real_count <= '0;
      occupied   <= '0;
      out_valid  <= 1'b0;
    end else begin
      // Raise the result once registered, drop it once taken
      if (state == S_RESULT && go_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid && cmd_t'(command) == CMD_SCHEDULE && count != cnt_t'(QUEUE_DEPTH)) begin
            occupied[free_slot] <= 1'b1;
          end
        end
        S_POP: begin
          if (count > cnt_t'(1)) begin
            head <= lnk_rd;
          end
          count          <= count - cnt_t'(1);
          occupied[head] <= !drop;
          if (!rd.virt) begin
            real_count <= real_count - cnt_t'(1);
          end
        end
        S_SCHED: begin
          if (count == '0) begin
            head       <= slot;
            count      <= cnt_t'(1);
            real_count <= real_count + cnt_t'(!virt);
          end
        end
        S_INS_B: begin
          if (lt && pos == '0) begin
            head <= slot;
          end
          count      <= count + cnt_t'(1);
          real_count <= real_count + cnt_t'(!virt);
        end
        default: ;
      endcase
    end
  end

  // Request operands, walk pointers and result fields
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          tid       <= task_id;
          d         <= delay;
          pl        <= after_ties;
          virt      <= background;
          drop      <= drop_task;
          slot      <= free_slot;
          popped    <= '0;
          elapsed_r <= '0;
          unique case (cmd_t'(command))
            CMD_SCHEDULE: err <= (count == cnt_t'(QUEUE_DEPTH)) ? ERR_FULL : ERR_NONE;
            CMD_REACH:    err <= (count == '0) ? ERR_EMPTY : ERR_NONE;
            CMD_RETIRE:   err <= (count == '0) ? ERR_EMPTY : ERR_NONE;
            default:      err <= ERR_NONE;
          endcase
        end
      end
      S_POP: begin
        popped <= rd.task_id;
        tid    <= rd.task_id;
        virt   <= rd.virt;
        slot   <= head;
        pl     <= (d == '0);
      end
      S_REACH: begin
        elapsed_r <= rd.delay;
      end
      S_SCHED: begin
        cur <= head;
        pos <= '0;
      end
      S_WALK: begin
        if (d > rd.delay && more1) begin
          d    <= d - rd.delay;
          prev <= cur;
          cur  <= lnk_rd;
          pos  <= pos + cnt_t'(1);
        end else begin
          cur_task  <= rd.task_id;
          cur_delay <= rd.delay;
          cur_virt  <= rd.virt;
          cur_link  <= lnk_rd;
        end
      end
      S_TIE: begin
        if (rd.delay == '0) begin
          prev      <= cur;
          cur       <= cur_link;
          pos       <= pos + cnt_t'(1);
          cur_task  <= rd.task_id;
          cur_delay <= rd.delay;
          cur_virt  <= rd.virt;
          cur_link  <= lnk_rd;
        end
      end
      S_INS_A: begin
        lt <= (d < cur_delay);
        if (!(d < cur_delay)) begin
          d <= d - cur_delay;
        end
      end
      S_RESULT: begin
        if (go_out) begin
          queue_empty      <= (count == '0);
          head_task        <= (count == '0) ? 8'd0 : rd.task_id;
          head_delay       <= (count == '0) ? '0 : rd.delay;
          timestep_done    <= (count == '0) || (rd.delay != '0);
          real_events_left <= (real_count != '0);
          popped_task      <= popped;
          elapsed          <= elapsed_r;
          error_code       <= err;
        end
      end
      default: ;
    endcase
  end

  // Checks
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= cnt_t'(QUEUE_DEPTH))
    else $error("entry count above queue depth");

  a_real_bound: assert property (@(posedge clk) disable iff (rst)
    real_count <= count)
    else $error("real event count above entry count");

  a_occ_match: assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE |-> $countones(occupied) == int'(count))
    else $error("occupied map disagrees with entry count");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> state != S_IDLE)
    else $error("request accepted but no work started");

endmodule

FILE: hdl/dleq_ram.sv
// ----------------------------------------------------------------------------
// dleq_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module dleq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write, then register the read word
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
